// ===== sv/wall_follow_error_estimator_assert.svh =====
// Assertion macros for the wall-follow error estimator checkers.
// Uses the clk and rst signals of the module that expands the macros.
`ifndef WALL_FOLLOW_ERROR_ESTIMATOR_ASSERT_SVH
`define WALL_FOLLOW_ERROR_ESTIMATOR_ASSERT_SVH

// Property checked at every edge outside of reset.
`define WFEE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define WFEE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/wfee_pkg.sv =====
// Shared types and constants for the wall-follow error estimator.
// No dependencies; used by the datapath, the top level and the checker.
package wfee_pkg;

  localparam int DIST_W = 16;
  localparam int RATE_W = 15;
  localparam int SRATE_W = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_WALL_THRESHOLD = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_LIMIT = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_DISTANCE = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE = 4'd3;

  // Register values after reset.
  localparam logic [DIST_W-1:0] RST_WALL_THRESHOLD = 16'd300;
  localparam logic [RATE_W-1:0] RST_RATE_LIMIT = 15'd350;
  localparam logic [DIST_W-1:0] RST_TARGET_DISTANCE = 16'd140;
  localparam logic [SRATE_W-1:0] RST_SAMPLE_RATE = 8'd10;

  // Error source codes.
  localparam logic [1:0] SRC_BOTH = 2'd0;
  localparam logic [1:0] SRC_LEFT = 2'd1;
  localparam logic [1:0] SRC_RIGHT = 2'd2;
  localparam logic [1:0] SRC_NONE = 2'd3;

  // Wall flag bit positions.
  localparam int FLAG_LEFT = 0;
  localparam int FLAG_RIGHT = 1;
  localparam int FLAG_AHEAD = 2;

  typedef struct packed {
    logic [DIST_W-1:0] rear_left_range;
    logic [DIST_W-1:0] front_left_range;
    logic [DIST_W-1:0] rear_right_range;
    logic [DIST_W-1:0] front_right_range;
    logic [DIST_W-1:0] ahead_range;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0]        left_distance;
    logic [DIST_W-1:0]        right_distance;
    logic [DIST_W-1:0]        ahead_distance;
    logic [2:0]               wall_flags;
    logic signed [DIST_W-1:0] distance_error;
    logic signed [DIST_W-1:0] derivative_error;
    logic [1:0]               error_source;
  } out_t;

  typedef struct packed {
    logic [DIST_W-1:0]  wall_threshold;
    logic [RATE_W-1:0]  rate_limit;
    logic [DIST_W-1:0]  target_distance;
    logic [SRATE_W-1:0] sample_rate;
  } cfg_t;

endpackage

// ===== sv/wall_follow_error_estimator.sv =====
// Wall-follow error estimator: frame register, datapath and result register.
// Depends on wfee_pkg and wfee_datapath.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one frame of five range
//   readings per request. out channel (out_valid/out_ready/out_data) returns
//   one result per frame, in order. cfg channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data) writes the four registers; cfg_ready is always
//   high and indexes beyond the list are ignored. Write registers only
//   while no frame is in flight.
//   A frame that is accepted is held in the frame register, and its result
//   is loaded into the output register once the output stage is free, which
//   raises out_valid. Throughput is one frame per cycle while the receiver
//   does not stall; the path between the registers holds two 16x8 multiplies
//   and compares. Reset clears both stages, the previous side means and loads
//   the register defaults. When the receiver stalls, the result holds in the
//   output register and one more frame can still be taken into the frame
//   register; in_ready then drops until the output drains.
module wall_follow_error_estimator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  wfee_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output wfee_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wfee_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wfee_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wfee_pkg::*;

  cfg_t              cfg;
  logic [DIST_W-1:0] prev_left_mean;
  logic [DIST_W-1:0] prev_right_mean;
  logic              frame_valid;
  in_t               frame;
  logic              result_valid;
  out_t              result;
  out_t              result_next;
  logic              result_free;
  logic              frame_move;

  // Handshake between the two stages.
  assign result_free = !result_valid || out_ready;
  assign frame_move  = frame_valid && result_free;
  assign in_ready    = !frame_valid || result_free;
  assign cfg_ready   = 1'b1;
  assign out_valid   = result_valid;
  assign out_data    = result;

  wfee_datapath u_datapath (
    .frame           (frame),
    .cfg             (cfg),
    .prev_left_mean  (prev_left_mean),
    .prev_right_mean (prev_right_mean),
    .result          (result_next)
  );

  // Control state, configuration registers and previous means.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid            <= 1'b0;
      result_valid           <= 1'b0;
      prev_left_mean         <= '0;
      prev_right_mean        <= '0;
      cfg.wall_threshold     <= RST_WALL_THRESHOLD;
      cfg.rate_limit         <= RST_RATE_LIMIT;
      cfg.target_distance    <= RST_TARGET_DISTANCE;
      cfg.sample_rate        <= RST_SAMPLE_RATE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WALL_THRESHOLD:  cfg.wall_threshold  <= cfg_data;
          REG_RATE_LIMIT:      cfg.rate_limit      <= cfg_data[RATE_W-1:0];
          REG_TARGET_DISTANCE: cfg.target_distance <= cfg_data;
          REG_SAMPLE_RATE:     cfg.sample_rate     <= cfg_data[SRATE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        frame_valid <= 1'b1;
      end else if (frame_move) begin
        frame_valid <= 1'b0;
      end
      if (frame_move) begin
        result_valid    <= 1'b1;
        prev_left_mean  <= result_next.left_distance;
        prev_right_mean <= result_next.right_distance;
      end else if (out_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame <= in_data;
    end
    if (frame_move) begin
      result <= result_next;
    end
  end

endmodule

// ===== sv/wfee_datapath.sv =====
// Combinational error computation for one frame of range readings.
// Depends on wfee_pkg for the frame, result and configuration types.
module wfee_datapath (
  input  wfee_pkg::in_t                    frame,
  input  wfee_pkg::cfg_t                   cfg,
  input  logic [wfee_pkg::DIST_W-1:0]      prev_left_mean,
  input  logic [wfee_pkg::DIST_W-1:0]      prev_right_mean,
  output wfee_pkg::out_t                   result
);
  import wfee_pkg::*;

  logic [DIST_W:0]             left_sum;
  logic [DIST_W:0]             right_sum;
  logic [DIST_W-1:0]           left;
  logic [DIST_W-1:0]           right;
  logic [DIST_W-1:0]           diff_l;
  logic [DIST_W-1:0]           diff_r;
  logic [DIST_W+SRATE_W-1:0]   prod_l;
  logic [DIST_W+SRATE_W-1:0]   prod_r;
  logic [DIST_W-1:0]           dl;
  logic [DIST_W-1:0]           dr;
  logic [DIST_W-1:0]           adl;
  logic [DIST_W-1:0]           adr;
  logic [DIST_W-1:0]           rate_lim;
  logic [DIST_W-1:0]           thr;
  logic                        bad;
  logic                        left_ok;
  logic                        right_ok;

  // Side means from the 17-bit sums.
  assign left_sum  = {1'b0, frame.rear_left_range} + {1'b0, frame.front_left_range};
  assign right_sum = {1'b0, frame.rear_right_range} + {1'b0, frame.front_right_range};
  assign left      = left_sum[DIST_W:1];
  assign right     = right_sum[DIST_W:1];
  assign thr       = cfg.wall_threshold;

  // Scaled changes of the means, wrapped to 16 bits; the right one is negated.
  assign diff_l = left - prev_left_mean;
  assign diff_r = right - prev_right_mean;
  assign prod_l = diff_l * cfg.sample_rate;
  assign prod_r = diff_r * cfg.sample_rate;
  assign dl     = prod_l[DIST_W-1:0];
  assign dr     = DIST_W'(0) - prod_r[DIST_W-1:0];

  // Magnitudes; the most negative value maps to 32768, which fits unsigned.
  assign adl      = dl[DIST_W-1] ? (~dl + DIST_W'(1)) : dl;
  assign adr      = dr[DIST_W-1] ? (~dr + DIST_W'(1)) : dr;
  assign rate_lim = {1'b0, cfg.rate_limit};

  // Frame checks are strict: values equal to a limit neither fail nor qualify.
  assign bad = (adl > rate_lim) || (adr > rate_lim) ||
               (frame.rear_left_range > thr) || (frame.front_left_range > thr) ||
               (frame.rear_right_range > thr) || (frame.front_right_range > thr);
  assign left_ok  = (adl < rate_lim) && (frame.rear_left_range < thr) &&
                    (frame.front_left_range < thr);
  assign right_ok = (adr < rate_lim) && (frame.rear_right_range < thr) &&
                    (frame.front_right_range < thr);

  // Pick the error source and form both errors.
  always_comb begin
    result.left_distance              = left;
    result.right_distance             = right;
    result.ahead_distance             = frame.ahead_range;
    result.wall_flags[FLAG_LEFT]      = left < thr;
    result.wall_flags[FLAG_RIGHT]     = right < thr;
    result.wall_flags[FLAG_AHEAD]     = frame.ahead_range < thr;
    if (!bad) begin
      result.distance_error   = left - right;
      result.derivative_error = dl + dr;
      result.error_source     = SRC_BOTH;
    end else if (left_ok) begin
      result.distance_error   = left - cfg.target_distance;
      result.derivative_error = {dl[DIST_W-2:0], 1'b0};
      result.error_source     = SRC_LEFT;
    end else if (right_ok) begin
      result.distance_error   = cfg.target_distance - right;
      result.derivative_error = {dr[DIST_W-2:0], 1'b0};
      result.error_source     = SRC_RIGHT;
    end else begin
      result.distance_error   = '0;
      result.derivative_error = '0;
      result.error_source     = SRC_NONE;
    end
  end

endmodule

// ===== sv/wfee_checker.sv =====
// Port-level checker for the wall-follow error estimator, bound to the top.
// Depends on wfee_pkg and the macros in wall_follow_error_estimator_assert.svh.
`include "wall_follow_error_estimator_assert.svh"

module wfee_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input wfee_pkg::out_t out_data
);
  import wfee_pkg::*;

  // Reset empties the output stage.
  `WFEE_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "output valid after reset")

  // A stalled result holds its payload.
  `WFEE_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_data),
               "stalled result changed")

  // With the output stage empty the frame stage can always take a request.
  `WFEE_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled while output empty")

  // No usable side gives zero errors.
  `WFEE_ASSERT(a_none_zero,
               out_valid && out_data.error_source == SRC_NONE |->
               out_data.distance_error == 0 && out_data.derivative_error == 0,
               "nonzero error with no usable side")

  // With both sides in use the centering error is left minus right.
  `WFEE_ASSERT(a_both_center,
               out_valid && out_data.error_source == SRC_BOTH |->
               out_data.distance_error ==
               $signed(DIST_W'(out_data.left_distance - out_data.right_distance)),
               "centering error mismatch")

endmodule

bind wall_follow_error_estimator wfee_checker u_wfee_checker (.*);
